/* src/segment_intersection_test_defines.svh */
// ----------------------------------------------------------------------------
// segment intersection test: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define SIT_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// shared constants for the segment intersection test pipeline
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH_DEF     = 24;
    localparam int COORD_FRAC_BITS_DEF = 8;

    // quotient bits of each divider, equal to the width of a hit coordinate
    localparam int QUOT_BITS = 32;
    localparam int HIT_WIDTH = QUOT_BITS;

    // hundredths of a pixel, doubled for round half away from zero
    localparam int K_HUNDRED = 100;
    localparam int K_NUM     = 2 * K_HUNDRED;

    localparam logic [QUOT_BITS-1:0] LIM_NEG = {1'b1, {(QUOT_BITS-1){1'b0}}};
    localparam logic [QUOT_BITS-1:0] LIM_POS = {1'b0, {(QUOT_BITS-1){1'b1}}};

endpackage

/* src/segment_intersection_test.sv */
// ----------------------------------------------------------------------------
// segment_intersection_test
// tests two line segments AB and CD for an intersection by Cramer's rule
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one beat per segment pair, eight
//   signed coordinates in 1/2^COORD_FRAC_BITS pixel plus i_count_ends.
//   A beat is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carries one beat per pair: o_crosses,
//   o_parallel_lines and the hit point in hundredths of a pixel, rounded
//   half away from zero and saturated to 32 bits (zero when parallel).
// Dividers: the x and y quotients come from two dividers that resolve
//   one quotient bit per stage.
// Throughput: one pair per cycle; every stage is registered and advances
//   together, so a new beat enters each cycle the output is not held.
// Stall: while the output beat is held by i_stall the whole pipeline
//   freezes and o_stall goes high; nothing is dropped or repeated.
// Reset: synchronous, active low; clears every stage valid bit, so the
//   pipeline drains empty and o_valid is low the cycle after reset.
// ----------------------------------------------------------------------------
module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_d_x,
    input  logic signed [COORD_WIDTH-1:0] i_d_y,
    input  logic                          i_count_ends,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_crosses,
    output logic                          o_parallel_lines,
    output logic signed [HIT_WIDTH-1:0]   o_hit_x,
    output logic signed [HIT_WIDTH-1:0]   o_hit_y
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = COORD_FRAC_BITS;
    localparam int DW   = W + 1;            // coordinate difference
    localparam int PW   = DW + W;           // difference times coordinate
    localparam int CW   = PW + 1;           // line constant
    localparam int EW   = 2 * DW + 1;       // determinant
    localparam int L    = W + 1;            // low split of a line constant
    localparam int HPW  = DW + CW - L;      // product with the high part
    localparam int LPW  = DW + L + 1;       // product with the low part
    localparam int MW   = DW + CW;          // full product
    localparam int NUMW = MW + 1;           // Cramer numerator
    localparam int NW   = NUMW + 9;         // divider dividend
    localparam int DDW  = EW + F + 1;       // divider divisor
    localparam int XW   = ((QUOT_BITS + F) > (W + 8) ? (QUOT_BITS + F) : (W + 8)) + 1;
    localparam int ZW   = XW + 1;
    localparam int SW   = F + 8;            // endpoint offset inside one pixel
    localparam int QW   = 2 * SW + 1;

    localparam int S_FLAG = 7;
    localparam int S_DIV  = 9 + QUOT_BITS;
    localparam int S_HIT  = S_DIV + 1;
    localparam int S_BOX  = S_DIV + 2;
    localparam int S_OUT  = S_DIV + 3;

    localparam longint S_VAL = longint'(K_HUNDRED) << F;
    localparam logic signed [XW-1:0] K100X = XW'(K_HUNDRED);
    localparam logic signed [ZW-1:0] S_Z   = ZW'(S_VAL);
    localparam logic signed [QW-1:0] S2_Q  = QW'(S_VAL * S_VAL);

    typedef struct packed {
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic signed [W-1:0] bx;
        logic signed [W-1:0] by;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic                ends;
        logic                par;
        logic                neg_x;
        logic                neg_y;
    } t_side;

    function automatic logic signed [QUOT_BITS-1:0] f_sat(
        input logic [QUOT_BITS-1:0] q,
        input logic                 ovf,
        input logic                 neg
    );
        logic [QUOT_BITS-1:0] lim;
        logic [QUOT_BITS-1:0] mag;
        lim = neg ? LIM_NEG : LIM_POS;
        mag = (ovf || q > lim) ? lim : q;
        return neg ? signed'(-mag) : signed'(mag);
    endfunction

    function automatic logic f_between(
        input logic signed [XW-1:0] p,
        input logic signed [XW-1:0] e0,
        input logic signed [XW-1:0] e1
    );
        return (p >= e0 && p <= e1) || (p >= e1 && p <= e0);
    endfunction

    logic              pipe_en;
    logic [S_OUT:1]    r_vld;
    t_side             n_side;
    t_side             n_flag;
    t_side             r_side [1:S_BOX];

    logic signed [DW-1:0]   r_s1_a1, r_s1_b1, r_s1_a2, r_s1_b2;
    logic signed [DW-1:0]   r_s2_a1, r_s2_b1, r_s2_a2, r_s2_b2;
    logic signed [PW-1:0]   r_s2_a1ax, r_s2_b1ay, r_s2_a2cx, r_s2_b2cy;
    logic signed [EW-2:0]   r_s2_a1b2, r_s2_a2b1;
    logic signed [DW-1:0]   r_s3_a1, r_s3_b1, r_s3_a2, r_s3_b2;
    logic signed [CW-1:0]   r_s3_c1, r_s3_c2;
    logic signed [EW-1:0]   r_s3_det, r_s4_det, r_s5_det, r_s6_det;
    logic signed [CW-L-1:0] c1_hi, c2_hi;
    logic signed [L:0]      c1_lo, c2_lo;
    logic signed [HPW-1:0]  r_s4_b2c1_h, r_s4_b1c2_h, r_s4_a1c2_h, r_s4_a2c1_h;
    logic signed [LPW-1:0]  r_s4_b2c1_l, r_s4_b1c2_l, r_s4_a1c2_l, r_s4_a2c1_l;
    logic signed [MW-1:0]   r_s5_b2c1, r_s5_b1c2, r_s5_a1c2, r_s5_a2c1;
    logic signed [NUMW-1:0] r_s6_nx, r_s6_ny;
    logic [NUMW-1:0]        r_s7_absnx, r_s7_absny;
    logic [EW-1:0]          r_s7_absdet;
    logic [NW-1:0]          r_s8_nx, r_s8_ny;
    logic [DDW-1:0]         r_s8_den;

    logic [QUOT_BITS-1:0]        quot_x, quot_y;
    logic                        ovf_x, ovf_y;
    logic signed [HIT_WIDTH-1:0] r_hx, r_hy, r_s43_hx, r_s43_hy;

    t_side                  sd_hit;
    logic signed [XW-1:0]   px, py;
    logic signed [XW-1:0]   ex100 [4];
    logic signed [XW-1:0]   ey100 [4];
    logic signed [ZW-1:0]   ddx [4];
    logic signed [ZW-1:0]   ddy [4];
    logic                   box_ok;
    logic signed [SW-1:0]   r_s43_dx [4];
    logic signed [SW-1:0]   r_s43_dy [4];
    logic                   r_s43_inr [4];
    logic                   r_s43_box;
    logic signed [QW-1:0]   sq [4];
    logic                   near_any;

    logic                        r_out_crosses, r_out_par;
    logic signed [HIT_WIDTH-1:0] r_out_hx, r_out_hy;

    // the whole pipe holds only while a finished beat waits downstream
    assign pipe_en = !(r_vld[S_OUT] && i_stall);
    assign o_stall = !pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[S_OUT-1:1], i_valid};
        end
    end

    always_comb begin
        n_side.ax    = i_a_x;
        n_side.ay    = i_a_y;
        n_side.bx    = i_b_x;
        n_side.by    = i_b_y;
        n_side.cx    = i_c_x;
        n_side.cy    = i_c_y;
        n_side.dx    = i_d_x;
        n_side.dy    = i_d_y;
        n_side.ends  = i_count_ends;
        n_side.par   = 1'b0;
        n_side.neg_x = 1'b0;
        n_side.neg_y = 1'b0;
    end

    always_comb begin
        n_flag       = r_side[S_FLAG-1];
        n_flag.par   = r_s6_det == '0;
        n_flag.neg_x = r_s6_nx[NUMW-1] ^ r_s6_det[EW-1];
        n_flag.neg_y = r_s6_ny[NUMW-1] ^ r_s6_det[EW-1];
    end

    // side data travels alongside; result flags join once the numerators exist
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_side[1] <= n_side;
            for (int s = 2; s <= S_BOX; s++) begin
                r_side[s] <= (s == S_FLAG) ? n_flag : r_side[s-1];
            end
        end
    end

    // line equations and determinant
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_a1 <= DW'(i_b_y) - DW'(i_a_y);
            r_s1_b1 <= DW'(i_a_x) - DW'(i_b_x);
            r_s1_a2 <= DW'(i_d_y) - DW'(i_c_y);
            r_s1_b2 <= DW'(i_c_x) - DW'(i_d_x);

            r_s2_a1   <= r_s1_a1;
            r_s2_b1   <= r_s1_b1;
            r_s2_a2   <= r_s1_a2;
            r_s2_b2   <= r_s1_b2;
            r_s2_a1ax <= PW'(r_s1_a1) * PW'(r_side[1].ax);
            r_s2_b1ay <= PW'(r_s1_b1) * PW'(r_side[1].ay);
            r_s2_a2cx <= PW'(r_s1_a2) * PW'(r_side[1].cx);
            r_s2_b2cy <= PW'(r_s1_b2) * PW'(r_side[1].cy);
            r_s2_a1b2 <= (EW-1)'(r_s1_a1) * (EW-1)'(r_s1_b2);
            r_s2_a2b1 <= (EW-1)'(r_s1_a2) * (EW-1)'(r_s1_b1);

            r_s3_a1  <= r_s2_a1;
            r_s3_b1  <= r_s2_b1;
            r_s3_a2  <= r_s2_a2;
            r_s3_b2  <= r_s2_b2;
            r_s3_c1  <= CW'(r_s2_a1ax) + CW'(r_s2_b1ay);
            r_s3_c2  <= CW'(r_s2_a2cx) + CW'(r_s2_b2cy);
            r_s3_det <= EW'(r_s2_a1b2) - EW'(r_s2_a2b1);
        end
    end

    // wide products split on the line constant: signed high part, unsigned low part
    assign c1_hi = signed'(r_s3_c1[CW-1:L]);
    assign c2_hi = signed'(r_s3_c2[CW-1:L]);
    assign c1_lo = signed'({1'b0, r_s3_c1[L-1:0]});
    assign c2_lo = signed'({1'b0, r_s3_c2[L-1:0]});

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s4_det    <= r_s3_det;
            r_s4_b2c1_h <= HPW'(r_s3_b2) * HPW'(c1_hi);
            r_s4_b1c2_h <= HPW'(r_s3_b1) * HPW'(c2_hi);
            r_s4_a1c2_h <= HPW'(r_s3_a1) * HPW'(c2_hi);
            r_s4_a2c1_h <= HPW'(r_s3_a2) * HPW'(c1_hi);
            r_s4_b2c1_l <= LPW'(r_s3_b2) * LPW'(c1_lo);
            r_s4_b1c2_l <= LPW'(r_s3_b1) * LPW'(c2_lo);
            r_s4_a1c2_l <= LPW'(r_s3_a1) * LPW'(c2_lo);
            r_s4_a2c1_l <= LPW'(r_s3_a2) * LPW'(c1_lo);

            r_s5_det  <= r_s4_det;
            r_s5_b2c1 <= (MW'(r_s4_b2c1_h) <<< L) + MW'(r_s4_b2c1_l);
            r_s5_b1c2 <= (MW'(r_s4_b1c2_h) <<< L) + MW'(r_s4_b1c2_l);
            r_s5_a1c2 <= (MW'(r_s4_a1c2_h) <<< L) + MW'(r_s4_a1c2_l);
            r_s5_a2c1 <= (MW'(r_s4_a2c1_h) <<< L) + MW'(r_s4_a2c1_l);

            r_s6_det <= r_s5_det;
            r_s6_nx  <= NUMW'(r_s5_b2c1) - NUMW'(r_s5_b1c2);
            r_s6_ny  <= NUMW'(r_s5_a1c2) - NUMW'(r_s5_a2c1);

            r_s7_absnx  <= r_s6_nx[NUMW-1] ? NUMW'(-r_s6_nx) : NUMW'(r_s6_nx);
            r_s7_absny  <= r_s6_ny[NUMW-1] ? NUMW'(-r_s6_ny) : NUMW'(r_s6_ny);
            r_s7_absdet <= r_s6_det[EW-1] ? EW'(-r_s6_det) : EW'(r_s6_det);

            // (2*100*|num| + 2^F*|det|) / (2^(F+1)*|det|) rounds half away from zero
            r_s8_nx  <= NW'(r_s7_absnx) * NW'(K_NUM) + (NW'(r_s7_absdet) << F);
            r_s8_ny  <= NW'(r_s7_absny) * NW'(K_NUM) + (NW'(r_s7_absdet) << F);
            r_s8_den <= DDW'(r_s7_absdet) << (F + 1);
        end
    end

    sit_div #(
        .NUM_W (NW),
        .DEN_W (DDW)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_num  (r_s8_nx),
        .i_den  (r_s8_den),
        .o_quot (quot_x),
        .o_ovf  (ovf_x)
    );

    sit_div #(
        .NUM_W (NW),
        .DEN_W (DDW)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_num  (r_s8_ny),
        .i_den  (r_s8_den),
        .o_quot (quot_y),
        .o_ovf  (ovf_y)
    );

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_hx <= r_side[S_DIV].par ? '0 : f_sat(quot_x, ovf_x, r_side[S_DIV].neg_x);
            r_hy <= r_side[S_DIV].par ? '0 : f_sat(quot_y, ovf_y, r_side[S_DIV].neg_y);
        end
    end

    // box test and endpoint offsets, all in units of 1/(100*2^F) pixel
    assign sd_hit = r_side[S_HIT];
    assign px     = XW'(r_hx) <<< F;
    assign py     = XW'(r_hy) <<< F;

    always_comb begin
        ex100[0] = XW'(sd_hit.ax) * K100X;
        ey100[0] = XW'(sd_hit.ay) * K100X;
        ex100[1] = XW'(sd_hit.bx) * K100X;
        ey100[1] = XW'(sd_hit.by) * K100X;
        ex100[2] = XW'(sd_hit.cx) * K100X;
        ey100[2] = XW'(sd_hit.cy) * K100X;
        ex100[3] = XW'(sd_hit.dx) * K100X;
        ey100[3] = XW'(sd_hit.dy) * K100X;
        for (int j = 0; j < 4; j++) begin
            ddx[j] = ZW'(px) - ZW'(ex100[j]);
            ddy[j] = ZW'(py) - ZW'(ey100[j]);
        end
        box_ok = f_between(px, ex100[0], ex100[1]) && f_between(py, ey100[0], ey100[1]) &&
                 f_between(px, ex100[2], ex100[3]) && f_between(py, ey100[2], ey100[3]);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s43_hx  <= r_hx;
            r_s43_hy  <= r_hy;
            r_s43_box <= box_ok;
            for (int j = 0; j < 4; j++) begin
                r_s43_dx[j]  <= signed'(ddx[j][SW-1:0]);
                r_s43_dy[j]  <= signed'(ddy[j][SW-1:0]);
                r_s43_inr[j] <= ddx[j] <= S_Z && ddx[j] >= -S_Z &&
                                ddy[j] <= S_Z && ddy[j] >= -S_Z;
            end
        end
    end

    // squared distance against one pixel squared, no root
    always_comb begin
        near_any = 1'b0;
        for (int j = 0; j < 4; j++) begin
            sq[j] = QW'(r_s43_dx[j]) * QW'(r_s43_dx[j]) +
                    QW'(r_s43_dy[j]) * QW'(r_s43_dy[j]);
            near_any = near_any | (r_s43_inr[j] && sq[j] <= S2_Q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_crosses <= !r_side[S_BOX].par && r_s43_box &&
                             (r_side[S_BOX].ends || !near_any);
            r_out_par     <= r_side[S_BOX].par;
            r_out_hx      <= r_s43_hx;
            r_out_hy      <= r_s43_hy;
        end
    end

    assign o_valid          = r_vld[S_OUT];
    assign o_crosses        = r_out_crosses;
    assign o_parallel_lines = r_out_par;
    assign o_hit_x          = r_out_hx;
    assign o_hit_y          = r_out_hy;

endmodule

/* src/sit_div.sv */
// ----------------------------------------------------------------------------
// sit_div
// pipelined restoring divider, one quotient bit per stage plus an
// overflow stage; stages advance on i_en, the MSB resolved first, LSB later
// ----------------------------------------------------------------------------
module sit_div
    import sit_pkg::*;
#(
    parameter int NUM_W = 96,
    parameter int DEN_W = 60
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    output logic [QUOT_BITS-1:0] o_quot,
    output logic                 o_ovf
);

    localparam int RW = (NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS;

    logic [RW-1:0]        r_rem [QUOT_BITS];
    logic [DEN_W-1:0]     r_den [QUOT_BITS];
    logic [QUOT_BITS-1:0] r_q   [QUOT_BITS+1];
    logic                 r_ovf [QUOT_BITS+1];

    // quotient would not fit: saturated downstream, later stages don't care
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= RW'(i_num) >= (RW'(i_den) << QUOT_BITS);
        end
    end

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
        localparam int BIT = QUOT_BITS - 1 - k;
        logic          take;
        logic [RW-1:0] sub;

        assign sub  = RW'(r_den[k]) << BIT;
        assign take = r_rem[k] >= sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= r_q[k] | (QUOT_BITS'(take) << BIT);
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k + 1 < QUOT_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= take ? r_rem[k] - sub : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quot = r_q[QUOT_BITS];
    assign o_ovf  = r_ovf[QUOT_BITS];

endmodule

/* src/sit_checker.sv */
// ----------------------------------------------------------------------------
// sit_checker
// port-level checks for the segment intersection test, bound to the top
// ----------------------------------------------------------------------------
`include "segment_intersection_test_defines.svh"

module sit_checker
    import sit_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_stall,
    input logic                        o_crosses,
    input logic                        o_parallel_lines,
    input logic signed [HIT_WIDTH-1:0] o_hit_x,
    input logic signed [HIT_WIDTH-1:0] o_hit_y
);

    // a parallel beat never crosses and carries a zero point
    `SIT_ASSERT_IMPL(a_par_zero, i_clk, i_rst_n, o_valid && o_parallel_lines, !o_crosses && o_hit_x == '0 && o_hit_y == '0, "parallel beat with crossing or nonzero point")

    // input side holds only behind a waiting output beat
    `SIT_ASSERT_IMPL(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a held output beat")

    `SIT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_crosses) && $stable(o_hit_x) && $stable(o_hit_y), "held output beat changed")

    `SIT_ASSERT_NEXT_RST(a_rst_empty, i_clk, !i_rst_n, !o_valid, "output valid right after reset")

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

/* tb/segment_intersection_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment intersection checker
// watches both channels of the segment intersection block, predicts each
// result from the accepted segment pair and compares it field by field
// ----------------------------------------------------------------------------
module segment_intersection_checker
    import sit_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_stall_in,
    input  logic signed [23:0]          i_a_x,
    input  logic signed [23:0]          i_a_y,
    input  logic signed [23:0]          i_b_x,
    input  logic signed [23:0]          i_b_y,
    input  logic signed [23:0]          i_c_x,
    input  logic signed [23:0]          i_c_y,
    input  logic signed [23:0]          i_d_x,
    input  logic signed [23:0]          i_d_y,
    input  logic                        i_count_ends,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_crosses,
    input  logic                        i_parallel_lines,
    input  logic signed [HIT_WIDTH-1:0] i_hit_x,
    input  logic signed [HIT_WIDTH-1:0] i_hit_y,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_crossings,
    output int                          o_parallels
);

    localparam int FRAC = 8;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic                        crosses;
        logic                        parallel_lines;
        logic signed [HIT_WIDTH-1:0] hit_x;
        logic signed [HIT_WIDTH-1:0] hit_y;
    } hit_result_t;

    hit_result_t expected_hits[$];

    // round(num * 100 / (den * 2^frac)) half away from zero, saturated to 32 bits
    function automatic longint hundredths_ratio(input wide_t num, input wide_t den);
        wide_t       n;
        wide_t       d;
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        n   = num * 100;
        d   = den * (1 << FRAC);
        neg = n[127] ^ d[127];
        un  = n[127] ? -n : n;
        ud  = d[127] ? -d : d;
        q   = (un + un + ud) / (ud + ud);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            q = lim;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic bit in_span(input longint p, input longint e0, input longint e1);
        longint lo;
        longint hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return p >= lo && p <= hi;
    endfunction

    // point in 1/(100*2^frac) pixel, endpoint in coordinate units
    function automatic bit close_to_end(input longint px, input longint py,
                                        input longint ex, input longint ey);
        longint s;
        longint dx;
        longint dy;
        s  = 100 << FRAC;
        dx = px - ex * 100;
        dy = py - ey * 100;
        if (dx > s || dx < -s || dy > s || dy < -s) begin
            return 1'b0;
        end
        return dx * dx + dy * dy <= s * s;
    endfunction

    function automatic hit_result_t intersect_segments(
        input logic signed [23:0] ax, input logic signed [23:0] ay,
        input logic signed [23:0] bx, input logic signed [23:0] by,
        input logic signed [23:0] cx, input logic signed [23:0] cy,
        input logic signed [23:0] dx, input logic signed [23:0] dy,
        input logic ends);
        hit_result_t r;
        wide_t  a1, b1, c1, a2, b2, c2, det;
        longint hx, hy, px, py;
        logic   hit;
        a1  = wide_t'(by) - wide_t'(ay);
        b1  = wide_t'(ax) - wide_t'(bx);
        a2  = wide_t'(dy) - wide_t'(cy);
        b2  = wide_t'(cx) - wide_t'(dx);
        c1  = a1 * wide_t'(ax) + b1 * wide_t'(ay);
        c2  = a2 * wide_t'(cx) + b2 * wide_t'(cy);
        det = a1 * b2 - a2 * b1;
        r   = '0;
        if (det == 0) begin
            r.parallel_lines = 1'b1;
            return r;
        end
        hx  = hundredths_ratio(b2 * c1 - b1 * c2, det);
        hy  = hundredths_ratio(a1 * c2 - a2 * c1, det);
        px  = hx * (1 << FRAC);
        py  = hy * (1 << FRAC);
        hit = in_span(px, longint'(ax) * 100, longint'(bx) * 100) &&
              in_span(py, longint'(ay) * 100, longint'(by) * 100) &&
              in_span(px, longint'(cx) * 100, longint'(dx) * 100) &&
              in_span(py, longint'(cy) * 100, longint'(dy) * 100);
        if (!ends && (close_to_end(px, py, ax, ay) || close_to_end(px, py, bx, by) ||
                      close_to_end(px, py, cx, cy) || close_to_end(px, py, dx, dy))) begin
            hit = 1'b0;
        end
        r.crosses = hit;
        r.hit_x   = hx[31:0];
        r.hit_y   = hy[31:0];
        return r;
    endfunction

    assign o_pending = expected_hits.size();

    always @(posedge i_clk) begin
        hit_result_t want;
        if (!i_rst_n) begin
            expected_hits.delete();
            o_errors    <= 0;
            o_results   <= 0;
            o_crossings <= 0;
            o_parallels <= 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                expected_hits.push_back(intersect_segments(i_a_x, i_a_y, i_b_x, i_b_y,
                    i_c_x, i_c_y, i_d_x, i_d_y, i_count_ends));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (expected_hits.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_hits.pop_front();
                    o_crossings <= o_crossings + want.crosses;
                    o_parallels <= o_parallels + want.parallel_lines;
                    if (want.crosses !== i_crosses || want.parallel_lines !== i_parallel_lines ||
                        want.hit_x !== i_hit_x || want.hit_y !== i_hit_y) begin
                        $display("%0t: mismatch expected cr=%0b par=%0b x=%0d y=%0d", $time,
                                 want.crosses, want.parallel_lines, want.hit_x, want.hit_y);
                        $display("%0t:          actual   cr=%0b par=%0b x=%0d y=%0d", $time,
                                 i_crosses, i_parallel_lines, i_hit_x, i_hit_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment intersection testbench
// directed and random segment pairs with random gaps on both channels;
// a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
    import sit_pkg::*;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    localparam int N_RANDOM  = 800;
    localparam int WATCHDOG  = 20000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [23:0]          i_a_x, i_a_y, i_b_x, i_b_y;
    logic signed [23:0]          i_c_x, i_c_y, i_d_x, i_d_y;
    logic                        i_count_ends;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_crosses;
    logic                        o_parallel_lines;
    logic signed [HIT_WIDTH-1:0] o_hit_x, o_hit_y;

    int errors, pending, results, crossings, parallels;
    int idle_cycles;
    int stall_left;
    bit no_gaps;

    segment_intersection_test dut (.*);

    segment_intersection_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_b_x(i_b_x), .i_b_y(i_b_y),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_d_x(i_d_x), .i_d_y(i_d_y),
        .i_count_ends(i_count_ends), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_crosses(o_crosses), .i_parallel_lines(o_parallel_lines),
        .i_hit_x(o_hit_x), .i_hit_y(o_hit_y),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_crossings(crossings), .o_parallels(parallels)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // receiver stalls: mostly short bursts, now and then a long one
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (!no_gaps && r < 20) begin
                stall_left <= $urandom_range(0, 2);
                i_stall    <= 1'b1;
            end else if (!no_gaps && r < 22) begin
                stall_left <= $urandom_range(10, 60);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("timeout: no beat for %0d cycles", WATCHDOG);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int clamp24(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return int'(v);
    endfunction

    function automatic int span_rand(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns once the beat is taken and any random gap after it has passed
    task automatic send_pair(input longint ax, input longint ay, input longint bx,
                             input longint by, input longint cx, input longint cy,
                             input longint dx, input longint dy, input bit ends);
        logic held;
        int   gap;
        i_valid      <= 1'b1;
        i_a_x        <= 24'(clamp24(ax));
        i_a_y        <= 24'(clamp24(ay));
        i_b_x        <= 24'(clamp24(bx));
        i_b_y        <= 24'(clamp24(by));
        i_c_x        <= 24'(clamp24(cx));
        i_c_y        <= 24'(clamp24(cy));
        i_d_x        <= 24'(clamp24(dx));
        i_d_y        <= 24'(clamp24(dy));
        i_count_ends <= ends;
        do begin
            @(negedge i_clk);
            held = o_stall;
            @(posedge i_clk);
        end while (held);
        gap = gap_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // the count is read between edges so the last accepted beat is included
    task automatic drain();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int span, kind, k;
        longint px, py, ax, ay, bx, by, cx, cy, ex, ey;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_count_ends = 1'b0;
        {i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y, i_d_x, i_d_y} = '0;
        no_gaps = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain crossing, both flag values
        send_pair(-1000, -1000, 1000, 1000, -1000, 1000, 1000, -1000, 1'b0);
        send_pair(-1000, -1000, 1000, 1000, -1000, 1000, 1000, -1000, 1'b1);
        // parallel and coincident lines
        send_pair(0, 0, 5000, 2500, 0, 100, 5000, 2600, 1'b1);
        send_pair(0, 0, 5000, 2500, 10000, 5000, 20000, 10000, 1'b1);
        // degenerate segments
        send_pair(300, 300, 300, 300, 0, 0, 700, 700, 1'b1);
        // crossing outside both boxes
        send_pair(0, 0, 100, 100, 1000, 0, 900, 50, 1'b1);
        // t junction on an endpoint and half a pixel away
        send_pair(0, 0, 2560, 0, 1280, 0, 1280, 2560, 1'b0);
        send_pair(0, 0, 2560, 0, 1280, 0, 1280, 2560, 1'b1);
        send_pair(0, 0, 2560, 0, 1280, -128, 1280, 2560, 1'b0);
        send_pair(0, 0, 2560, 0, 1280, -300, 1280, 2560, 1'b0);
        // exactly one pixel from an endpoint
        send_pair(0, 0, 2560, 0, 1280, -256, 1280, 2560, 1'b0);
        // rounding on quarters of a unit
        send_pair(0, 0, 3, 1, 0, 1, 1, 0, 1'b1);
        send_pair(0, 0, -3, -1, 0, -1, -1, 0, 1'b1);
        // coordinate extremes
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
        send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
        send_pair(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX, 1'b0);
        // near-parallel lines meeting far away: saturates both ways
        send_pair(0, 0, COORD_MAX, 1, 0, 256, COORD_MAX - 1, 257, 1'b1);
        send_pair(0, 0, COORD_MAX, 1, 0, -256, COORD_MAX - 1, -257, 1'b1);
        send_pair(0, 0, 1, COORD_MAX, 256, 0, 257, COORD_MAX - 1, 1'b0);

        // sender holds off until the pipeline is empty
        i_valid <= 1'b0;
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                drain();
                @(posedge i_clk);
            end
            k    = $urandom_range(0, 2);
            span = (k == 0) ? 4000 : (k == 1) ? 200000 : COORD_MAX;
            kind = $urandom_range(0, 99);
            px   = span_rand(span / 2);
            py   = span_rand(span / 2);
            ax   = px + span_rand(span / 2);
            ay   = py + span_rand(span / 2);
            cx   = px + span_rand(span / 2);
            cy   = py + span_rand(span / 2);
            if (kind < 50) begin
                // segments crossing at their common midpoint
                send_pair(ax, ay, 2 * px - ax, 2 * py - ay,
                          cx, cy, 2 * px - cx, 2 * py - cy, $urandom_range(0, 1));
            end else if (kind < 68) begin
                // second segment starts within 400 units of an endpoint on each axis
                ex = ax + span_rand(400);
                ey = ay + span_rand(400);
                send_pair(ax, ay, 2 * px - ax, 2 * py - ay,
                          ex, ey, ex + span_rand(span / 4), ey + span_rand(span / 4),
                          $urandom_range(0, 1));
            end else if (kind < 78) begin
                // parallel by construction
                bx = span_rand(300);
                by = span_rand(300);
                k  = $urandom_range(1, 4);
                send_pair(ax, ay, ax + bx, ay + by, cx, cy, cx + k * bx, cy + k * by,
                          $urandom_range(0, 1));
            end else begin
                send_pair(span_rand(COORD_MAX), span_rand(COORD_MAX), span_rand(COORD_MAX),
                          span_rand(COORD_MAX), span_rand(COORD_MAX), span_rand(COORD_MAX),
                          span_rand(COORD_MAX),
                          int'(COORD_MIN + $urandom_range(0, 16777215)),
                          $urandom_range(0, 1));
            end
        end

        i_valid <= 1'b0;
        drain();
        repeat (60) @(posedge i_clk);

        $display("covered %0d segment pairs: %0d crossing, %0d parallel", results,
                 crossings, parallels);
        $display("directed extremes, endpoint cases, saturation and random gaps both sides");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
